// File: rtl/core/aslt_pkg.sv
// Package for the aligned symbol layout table: request and status codes,
// the table entry type, chain control struct and the alignment helpers.
// No dependencies.
`default_nettype none
package aslt_pkg;

    localparam int DEF_MAX_ENTRIES = 128;

    typedef enum logic [2:0] {
        REQ_ADD     = 3'd0,
        REQ_UPDATE  = 3'd1,
        REQ_DELETE  = 3'd2,
        REQ_SWAP    = 3'd3,
        REQ_ADDRESS = 3'd4,
        REQ_SIZE    = 3'd5,
        REQ_SECTION = 3'd6,
        REQ_NONE    = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_FULL     = 2'd2,
        ST_BADALIGN = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] id;
        logic [16:0] align;
        logic [31:0] size;
    } entry_t;

    // broadcast commands to every cell of the chain
    typedef struct packed {
        logic rotate;   // every cell takes its upper neighbor
        logic del;      // cells at or above del_pos take their upper neighbor
        logic wr_a;     // cell at pos_a loads data_a
        logic wr_b;     // cell at pos_b loads data_b
    } chain_cmd_t;

    function automatic logic align_ok(input logic [16:0] a);
        return (a & (a - 17'd1)) == 17'd0;
    endfunction

    function automatic logic [31:0] round_up(input logic [31:0] x, input logic [16:0] a);
        logic [31:0] m;
        m = (a == 17'd0) ? 32'd0 : ({15'd0, a} - 32'd1);
        return (x + m) & ~m;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/aslt_cell.sv
// One table slot of the symbol chain: holds one entry, shifts from its
// upper neighbor or loads a broadcast entry. Depends on aslt_pkg.
`default_nettype none
module aslt_cell
    import aslt_pkg::*;
#(
    parameter int PW  = 7,
    parameter int IDX = 0
) (
    input  wire logic          clk,
    input  wire chain_cmd_t    cmd,
    input  wire logic [PW-1:0] pos_a,
    input  wire logic [PW-1:0] pos_b,
    input  wire logic [PW-1:0] del_pos,
    input  wire entry_t        data_a,
    input  wire entry_t        data_b,
    input  wire entry_t        upper,
    output entry_t             ent
);
    entry_t ent_reg;
    logic   sel_a, sel_b, shift;

    always_comb
    begin
        sel_a = cmd.wr_a && (pos_a == PW'(IDX));
        sel_b = cmd.wr_b && (pos_b == PW'(IDX));
        shift = cmd.rotate || (cmd.del && (del_pos <= PW'(IDX)));
    end

    always_ff @(posedge clk)
    begin
        if (sel_a)
        begin
            ent_reg <= data_a;
        end
        else if (sel_b)
        begin
            ent_reg <= data_b;
        end
        else if (shift)
        begin
            ent_reg <= upper;
        end
    end

    assign ent = ent_reg;
endmodule
`default_nettype wire

// File: rtl/core/aslt_chain.sv
// Ring of table cells; cell 0 is the head seen by the sequencer, the top
// cell wraps around to cell 0. Depends on aslt_pkg and aslt_cell.
`default_nettype none
module aslt_chain
    import aslt_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int PW = $clog2(MAX_ENTRIES)
) (
    input  wire logic          clk,
    input  wire chain_cmd_t    cmd,
    input  wire logic [PW-1:0] pos_a,
    input  wire logic [PW-1:0] pos_b,
    input  wire logic [PW-1:0] del_pos,
    input  wire entry_t        data_a,
    input  wire entry_t        data_b,
    output entry_t             head
);
    entry_t ents [MAX_ENTRIES];

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        aslt_cell #(.PW(PW), .IDX(i)) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .pos_a   (pos_a),
            .pos_b   (pos_b),
            .del_pos (del_pos),
            .data_a  (data_a),
            .data_b  (data_b),
            .upper   (ents[(i + 1) % MAX_ENTRIES]),
            .ent     (ents[i])
        );
    end

    assign head = ents[0];
endmodule
`default_nettype wire

// File: rtl/core/aligned_symbol_layout_table.sv
// Aligned symbol layout table, top level: request sequencer, layout
// accumulator and output register around the cell ring.
// Depends on aslt_pkg and aslt_chain.
//
// Channels: requests on in_valid/in_ready with req_type, sym_id, other_id,
// align_bytes, byte_count; one result per request on out_valid/out_ready with
// status, assigned_id, value; section_base written on cfg_valid/cfg_ready/
// cfg_data (always ready, write only while idle).
// One request at a time. Add and unknown requests go from acceptance
// straight to the apply state; every other request first passes through a
// scan, one full revolution of the cell ring past the head, where lookup and
// the layout prefix sum are done one entry per cycle, and then the apply
// state, which registers the result and updates the ring where the request
// changes it. A new request is taken only once the last one is applied.
// A result waits in the output register; while the receiver stalls the
// next request may still be accepted and scanned, but its apply cycle waits
// until the output register is free.
// Reset clears entry count, id counter, section_base and the output valid;
// table contents are undefined until written and are never read beyond the
// entry count.
`default_nettype none
module aligned_symbol_layout_table
    import aslt_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  req_type,
    input  wire logic [31:0] sym_id,
    input  wire logic [31:0] other_id,
    input  wire logic [16:0] align_bytes,
    input  wire logic [31:0] byte_count,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [31:0]      assigned_id,
    output logic [31:0]      value,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    localparam int PW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    req_t        req_reg;
    logic [31:0] id_reg, oid_reg, sz_reg;
    logic [16:0] al_reg;
    logic [PW-1:0] k_reg, p_reg, q_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] idc_reg, idc_next, base_reg, g_reg, addr_reg;
    logic        fp_reg, fq_reg;
    entry_t      ent_p_reg, ent_q_reg, head;
    logic        out_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [31:0] assigned_reg, assigned_next, value_reg, value_next;

    chain_cmd_t    cmd;
    logic [PW-1:0] pos_a, pos_b;
    entry_t        data_a, data_b;

    logic in_acc, apply_go, head_valid, match_p, match_q;

    aslt_chain #(.MAX_ENTRIES(MAX_ENTRIES), .PW(PW)) u_chain (
        .clk     (clk),
        .cmd     (cmd),
        .pos_a   (pos_a),
        .pos_b   (pos_b),
        .del_pos (p_reg),
        .data_a  (data_a),
        .data_b  (data_b),
        .head    (head)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign apply_go  = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);

    assign head_valid = (CW'(k_reg) < count_reg);
    assign match_p    = head_valid && !fp_reg && (head.id == id_reg);
    assign match_q    = head_valid && !fq_reg && (head.id == oid_reg);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        pos_a         = p_reg;
        pos_b         = q_reg;
        data_a        = ent_q_reg;
        data_b        = ent_p_reg;
        count_next    = count_reg;
        idc_next      = idc_reg;
        status_next   = ST_OK;
        assigned_next = 32'd0;
        value_next    = 32'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (req_type == REQ_ADD || req_type == REQ_NONE)
                    begin
                        state_next = S_APPLY;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.rotate = 1'b1;
                if (k_reg == PW'(MAX_ENTRIES - 1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = S_IDLE;
                    case (req_reg)
                        REQ_ADD:
                        begin
                            if (!align_ok(al_reg))
                            begin
                                status_next = ST_BADALIGN;
                            end
                            else if (count_reg == CW'(MAX_ENTRIES))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.wr_a      = 1'b1;
                                pos_a         = count_reg[PW-1:0];
                                data_a        = '{id: idc_reg, align: al_reg, size: sz_reg};
                                count_next    = count_reg + CW'(1);
                                assigned_next = idc_reg;
                                idc_next      = idc_reg + 32'd1;
                            end
                        end
                        REQ_UPDATE:
                        begin
                            if (!align_ok(al_reg))
                            begin
                                status_next = ST_BADALIGN;
                            end
                            else if (!fp_reg)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else
                            begin
                                cmd.wr_a = 1'b1;
                                data_a   = '{id: ent_p_reg.id, align: al_reg, size: sz_reg};
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (!fp_reg)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else
                            begin
                                cmd.del    = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        REQ_SWAP:
                        begin
                            if (!fp_reg || !fq_reg)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else
                            begin
                                cmd.wr_a = 1'b1;
                                cmd.wr_b = 1'b1;
                            end
                        end
                        REQ_ADDRESS:
                        begin
                            if (!fp_reg)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else
                            begin
                                value_next = addr_reg;
                            end
                        end
                        REQ_SIZE:
                        begin
                            if (!fp_reg)
                            begin
                                status_next = ST_ABSENT;
                            end
                            else
                            begin
                                value_next = ent_p_reg.size;
                            end
                        end
                        REQ_SECTION:
                        begin
                            value_next = g_reg - base_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idc_reg       <= 32'd0;
            base_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idc_reg   <= idc_next;
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (apply_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_reg <= req_t'(req_type);
            id_reg  <= sym_id;
            oid_reg <= other_id;
            al_reg  <= align_bytes;
            sz_reg  <= byte_count;
            k_reg   <= '0;
            fp_reg  <= 1'b0;
            fq_reg  <= 1'b0;
            g_reg   <= base_reg;
        end
        else if (state_reg == S_SCAN)
        begin
            k_reg <= k_reg + PW'(1);
            if (match_p)
            begin
                fp_reg    <= 1'b1;
                p_reg     <= k_reg;
                ent_p_reg <= head;
                addr_reg  <= round_up(g_reg, head.align);
            end
            if (match_q)
            begin
                fq_reg    <= 1'b1;
                q_reg     <= k_reg;
                ent_q_reg <= head;
            end
            if (head_valid)
            begin
                g_reg <= round_up(g_reg, head.align) + head.size;
            end
        end
        if (apply_go)
        begin
            status_reg   <= status_next;
            assigned_reg <= assigned_next;
            value_reg    <= value_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign assigned_id = assigned_reg;
    assign value       = value_reg;
endmodule
`default_nettype wire
